### src/lj_pem_pkg.sv
// Shared widths, register codes, reset values and types for the
// Lennard-Jones pair energy unit. No dependencies.
package lj_pem_pkg;

  localparam int CoordW    = 24;   // coordinates and wrapped separations
  localparam int DiffW     = 25;   // raw and wrapped difference
  localparam int BoxW      = 23;
  localparam int SigW      = 20;
  localparam int EpsW      = 24;
  localparam int LimW      = 23;
  localparam int SqW       = 48;   // one axis squared
  localparam int R2W       = 50;   // sum of three squares
  localparam int S2W       = 2 * SigW;
  localparam int Cl2W      = 2 * LimW;
  localparam int QFrac     = 32;
  localparam int QW        = 37;   // s^2/r^2 below 32, 32 fraction bits
  localparam int S2LoW     = QW - QFrac;
  localparam int DivSteps  = QW;
  localparam int RootW     = 25;
  localparam int SqrtSteps = RootW;
  localparam int SqRemW    = RootW + 3;
  localparam int EnergyW   = 32;

  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 24;
  localparam int InDataW   = 6 * CoordW;
  localparam int OutDataW  = 4 * CoordW + EnergyW;
  localparam int OutUserW  = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBoxX     = 3'd0,
    CfgBoxY     = 3'd1,
    CfgBoxZ     = 3'd2,
    CfgSigma    = 3'd3,
    CfgEps      = 3'd4,
    CfgCloseLim = 3'd5
  } cfg_idx_e;

  localparam logic [BoxW-1:0] BoxReset   = 23'd3276800;
  localparam logic [SigW-1:0] SigReset   = 20'd189389;
  localparam logic [EpsW-1:0] EpsReset   = 24'd58780;
  localparam logic [LimW-1:0] LimReset   = 23'd131072;

  localparam logic [EnergyW-1:0] EMax = 32'h7FFF_FFFF;
  localparam logic [EnergyW-1:0] EMin = 32'h8000_0000;

  typedef struct packed {
    logic [CoordW-1:0] dx;
    logic [CoordW-1:0] dy;
    logic [CoordW-1:0] dz;
    logic              zero;
    logic              big;
    logic              close;
  } side_t;

  typedef struct packed {
    logic               warn;
    logic               sat;
    logic [EnergyW-1:0] energy;
    logic [CoordW-1:0]  pdist;
    logic [CoordW-1:0]  dz;
    logic [CoordW-1:0]  dy;
    logic [CoordW-1:0]  dx;
  } res_t;

  function automatic logic [CoordW-1:0] sat_coord(input logic signed [DiffW-1:0] v);
    logic [CoordW-1:0] r;
    if (v > $signed({2'b00, {(CoordW-1){1'b1}}})) begin
      r = {1'b0, {(CoordW-1){1'b1}}};
    end else if (v < $signed({2'b11, {(CoordW-1){1'b0}}})) begin
      r = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      r = v[CoordW-1:0];
    end
    return r;
  endfunction

endpackage

### src/lj_pair_energy_min_image_unit.sv
// Lennard-Jones 12-6 pair energy with minimum-image wrap, fully pipelined.
// Takes one pair per cycle while the output skid register is empty.
// The depth is set by the 37-stage restoring divider (one quotient bit per stage),
// with the 25-stage square root running alongside it.
// A skid register at the output keeps s_axis_tready a flop output.
// Reset (async, active low) empties the pipe and loads default registers.
module lj_pair_energy_min_image_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z
  input  logic [lj_pem_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // wrapped_dx, wrapped_dy, wrapped_dz, pair_distance, pair_energy
  output logic [lj_pem_pkg::OutDataW-1:0]   m_axis_tdata,
  // energy_saturated, close_warning
  output logic [lj_pem_pkg::OutUserW-1:0]   m_axis_tuser,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lj_pem_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [lj_pem_pkg::CfgDataW-1:0]   cfg_data_i
);
  import lj_pem_pkg::*;

  // configuration
  logic [BoxW-1:0] box_q [3];
  logic [SigW-1:0] sig_q;
  logic [EpsW-1:0] eps_q;
  logic [LimW-1:0] lim_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q[0] <= BoxReset;
      box_q[1] <= BoxReset;
      box_q[2] <= BoxReset;
      sig_q    <= SigReset;
      eps_q    <= EpsReset;
      lim_q    <= LimReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgBoxX:     box_q[0] <= cfg_data_i[BoxW-1:0];
        CfgBoxY:     box_q[1] <= cfg_data_i[BoxW-1:0];
        CfgBoxZ:     box_q[2] <= cfg_data_i[BoxW-1:0];
        CfgSigma:    sig_q    <= cfg_data_i[SigW-1:0];
        CfgEps:      eps_q    <= cfg_data_i[EpsW-1:0];
        CfgCloseLim: lim_q    <= cfg_data_i[LimW-1:0];
        default: ;
      endcase
    end
  end

  // global advance: the pipe moves unless the skid register is occupied
  logic en;
  logic skid_vld_q, out_vld_q;
  res_t skid_q, out_q;

  assign en            = !skid_vld_q;
  assign s_axis_tready = en;

  // F1: raw differences
  logic                    f1_vld_q;
  logic signed [DiffW-1:0] f1_d_q [3];
  // F2: wrapped
  logic                    f2_vld_q;
  logic signed [DiffW-1:0] f2_w_q [3];
  logic [S2W-1:0]          f2_s2_q;
  logic [Cl2W-1:0]         f2_cl2_q;
  // F3: magnitude and saturated outputs
  logic                    f3_vld_q;
  logic [CoordW-1:0]       f3_a_q [3];
  logic [CoordW-1:0]       f3_sat_q [3];
  logic [S2W-1:0]          f3_s2_q;
  logic [Cl2W-1:0]         f3_cl2_q;
  // F4: squares
  logic                    f4_vld_q;
  logic [SqW-1:0]          f4_sq_q [3];
  logic [CoordW-1:0]       f4_sat_q [3];
  logic [S2W-1:0]          f4_s2_q;
  logic [Cl2W-1:0]         f4_cl2_q;
  // F5: r^2
  logic                    f5_vld_q;
  logic [R2W-1:0]          f5_r2_q;
  logic [CoordW-1:0]       f5_sat_q [3];
  logic [S2W-1:0]          f5_s2_q;
  logic [Cl2W-1:0]         f5_cl2_q;

  logic signed [DiffW-1:0] f1_d_d [3];
  logic signed [DiffW-1:0] f2_w_d [3];
  logic [CoordW-1:0]       f3_a_d [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      f1_d_d[a] = $signed({s_axis_tdata[3*CoordW + a*CoordW + CoordW-1],
                           s_axis_tdata[3*CoordW + a*CoordW +: CoordW]})
                - $signed({s_axis_tdata[a*CoordW + CoordW-1],
                           s_axis_tdata[a*CoordW +: CoordW]});
    end
  end

  always_comb begin
    logic signed [DiffW:0] d2;
    logic signed [DiffW:0] len;
    for (int a = 0; a < 3; a++) begin
      d2  = {f1_d_q[a], 1'b0};
      len = $signed({{(DiffW+1-BoxW){1'b0}}, box_q[a]});
      if (d2 >= len) begin
        f2_w_d[a] = f1_d_q[a] - $signed({{(DiffW-BoxW){1'b0}}, box_q[a]});
      end else if (d2 < -len) begin
        f2_w_d[a] = f1_d_q[a] + $signed({{(DiffW-BoxW){1'b0}}, box_q[a]});
      end else begin
        f2_w_d[a] = f1_d_q[a];
      end
    end
  end

  always_comb begin
    logic signed [DiffW-1:0] n;
    for (int a = 0; a < 3; a++) begin
      n         = -f2_w_q[a];
      // wrapped magnitude never reaches 2^24
      f3_a_d[a] = f2_w_q[a][DiffW-1] ? n[CoordW-1:0] : f2_w_q[a][CoordW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
      f2_vld_q <= 1'b0;
      f3_vld_q <= 1'b0;
      f4_vld_q <= 1'b0;
      f5_vld_q <= 1'b0;
    end else if (en) begin
      f1_vld_q <= s_axis_tvalid;
      f2_vld_q <= f1_vld_q;
      f3_vld_q <= f2_vld_q;
      f4_vld_q <= f3_vld_q;
      f5_vld_q <= f4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        f1_d_q[a]   <= f1_d_d[a];
        f2_w_q[a]   <= f2_w_d[a];
        f3_a_q[a]   <= f3_a_d[a];
        f3_sat_q[a] <= sat_coord(f2_w_q[a]);
        f4_sq_q[a]  <= f3_a_q[a] * f3_a_q[a];
        f4_sat_q[a] <= f3_sat_q[a];
        f5_sat_q[a] <= f4_sat_q[a];
      end
      f2_s2_q  <= sig_q * sig_q;
      f2_cl2_q <= lim_q * lim_q;
      f3_s2_q  <= f2_s2_q;
      f3_cl2_q <= f2_cl2_q;
      f4_s2_q  <= f3_s2_q;
      f4_cl2_q <= f3_cl2_q;
      f5_r2_q  <= {2'b00, f4_sq_q[0]} + {2'b00, f4_sq_q[1]} + {2'b00, f4_sq_q[2]};
      f5_s2_q  <= f4_s2_q;
      f5_cl2_q <= f4_cl2_q;
    end
  end

  // divider (one quotient bit per stage) with square root alongside
  side_t f5_side;
  always_comb begin
    f5_side.dx    = f5_sat_q[0];
    f5_side.dy    = f5_sat_q[1];
    f5_side.dz    = f5_sat_q[2];
    f5_side.zero  = (f5_r2_q == '0);
    f5_side.big   = ({{(R2W+5-S2W){1'b0}}, f5_s2_q} >= {f5_r2_q, 5'b00000});
    f5_side.close = (f5_r2_q < {{(R2W-Cl2W){1'b0}}, f5_cl2_q});
  end

  logic                dv_vld_q  [DivSteps];
  logic [R2W-1:0]      dv_r2_q   [DivSteps];
  logic [R2W-1:0]      dv_rem_q  [DivSteps];
  logic [QW-1:0]       dv_q_q    [DivSteps];
  logic [S2LoW-1:0]    dv_s2lo_q [DivSteps];
  side_t               dv_side_q [DivSteps];
  logic [SqRemW-1:0]   sq_rem_q  [DivSteps];
  logic [RootW-1:0]    sq_root_q [DivSteps];

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    localparam int Kb = DivSteps - 1 - k;
    logic              pv;
    logic [R2W-1:0]    pr2;
    logic [R2W-1:0]    prem;
    logic [QW-1:0]     pq;
    logic [S2LoW-1:0]  ps2;
    side_t             pside;
    logic [SqRemW-1:0] psr;
    logic [RootW-1:0]  prt;
    logic              nb;
    logic [R2W:0]      rsh;
    logic              ge;
    logic [R2W:0]      rsub;
    logic [SqRemW-1:0] nsr;
    logic [RootW-1:0]  nrt;

    if (k == 0) begin : g_first
      assign pv    = f5_vld_q;
      assign pr2   = f5_r2_q;
      assign prem  = {{(R2W-S2W+S2LoW){1'b0}}, f5_s2_q[S2W-1:S2LoW]};
      assign pq    = '0;
      assign ps2   = f5_s2_q[S2LoW-1:0];
      assign pside = f5_side;
      assign psr   = '0;
      assign prt   = '0;
    end else begin : g_next
      assign pv    = dv_vld_q[k-1];
      assign pr2   = dv_r2_q[k-1];
      assign prem  = dv_rem_q[k-1];
      assign pq    = dv_q_q[k-1];
      assign ps2   = dv_s2lo_q[k-1];
      assign pside = dv_side_q[k-1];
      assign psr   = sq_rem_q[k-1];
      assign prt   = sq_root_q[k-1];
    end

    if (Kb >= QFrac) begin : g_bit
      assign nb = ps2[Kb-QFrac];
    end else begin : g_zero
      assign nb = 1'b0;
    end

    assign rsh  = {prem, nb};
    assign ge   = (rsh >= {1'b0, pr2});
    assign rsub = rsh - {1'b0, pr2};

    if (k < SqrtSteps) begin : g_sqrt
      localparam int B = SqrtSteps - 1 - k;
      logic [SqRemW-1:0] ssh;
      logic [SqRemW-1:0] trial;
      logic              sge;
      assign ssh   = {psr[SqRemW-3:0], pr2[2*B+1 -: 2]};
      assign trial = {1'b0, prt, 2'b01};
      assign sge   = (ssh >= trial);
      assign nsr   = sge ? ssh - trial : ssh;
      assign nrt   = {prt[RootW-2:0], sge};
    end else begin : g_hold
      assign nsr = psr;
      assign nrt = prt;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k] <= 1'b0;
      end else if (en) begin
        dv_vld_q[k] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_r2_q[k]   <= pr2;
        dv_rem_q[k]  <= ge ? rsub[R2W-1:0] : rsh[R2W-1:0];
        dv_q_q[k]    <= {pq[QW-2:0], ge};
        dv_s2lo_q[k] <= ps2;
        dv_side_q[k] <= pside;
        sq_rem_q[k]  <= nsr;
        sq_root_q[k] <= nrt;
      end
    end
  end

  // power chain: q^2, q^3, q^6, x^2 - x, times 4*eps
  logic [QW-1:0]      dq;
  logic [CoordW-1:0]  ddist;
  assign dq    = dv_q_q[DivSteps-1];
  assign ddist = sq_root_q[DivSteps-1][RootW-1] ? {CoordW{1'b1}}
                                                : sq_root_q[DivSteps-1][CoordW-1:0];

  logic        m_vld_q [9];
  side_t       m_side_q [9];
  logic [CoordW-1:0] m_dist_q [9];

  logic [63:0] m1_ll_q;
  logic [36:0] m1_lh_q;
  logic [9:0]  m1_hh_q;
  logic [QW-1:0] m1_q_q, m2_q_q;
  logic [41:0] m2_q2_q;
  logic [63:0] m3_ll_q;
  logic [36:0] m3_lh_q;
  logic [41:0] m3_hl_q;
  logic [14:0] m3_hh_q;
  logic [46:0] m4_x_q, m5_x_q, m6_x_q;
  logic [63:0] m5_ll_q;
  logic [46:0] m5_lh_q;
  logic [29:0] m5_hh_q;
  logic [61:0] m6_x2_q;
  logic [61:0] m7_t_q;
  logic        m7_neg_q, m8_neg_q, m9_neg_q;
  logic [55:0] m8_tl_q;
  logic [53:0] m8_th_q;
  logic [55:0] m9_mag_q;

  logic [73:0] m2_sum;
  logic [78:0] m4_sum;
  logic [93:0] m6_sum;
  logic        m7_neg;
  logic [85:0] m9_sum;

  assign m2_sum = {10'b0, m1_ll_q} + {4'b0, m1_lh_q, 33'b0} + {m1_hh_q, 64'b0};
  assign m4_sum = {15'b0, m3_ll_q} + {10'b0, m3_lh_q, 32'b0}
                + {5'b0, m3_hl_q, 32'b0} + {m3_hh_q, 64'b0};
  assign m6_sum = {30'b0, m5_ll_q} + {14'b0, m5_lh_q, 33'b0} + {m5_hh_q, 64'b0};
  assign m7_neg = (m6_x2_q < {15'b0, m6_x_q});
  assign m9_sum = {30'b0, m8_tl_q} + {m8_th_q, 32'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) m_vld_q[i] <= 1'b0;
    end else if (en) begin
      m_vld_q[0] <= dv_vld_q[DivSteps-1];
      for (int i = 1; i < 9; i++) m_vld_q[i] <= m_vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_side_q[0] <= dv_side_q[DivSteps-1];
      m_dist_q[0] <= ddist;
      for (int i = 1; i < 9; i++) begin
        m_side_q[i] <= m_side_q[i-1];
        m_dist_q[i] <= m_dist_q[i-1];
      end
      m1_ll_q  <= dq[31:0] * dq[31:0];
      m1_lh_q  <= dq[31:0] * dq[QW-1:32];
      m1_hh_q  <= dq[QW-1:32] * dq[QW-1:32];
      m1_q_q   <= dq;
      m2_q2_q  <= m2_sum[73:32];
      m2_q_q   <= m1_q_q;
      m3_ll_q  <= m2_q2_q[31:0] * m2_q_q[31:0];
      m3_lh_q  <= m2_q2_q[31:0] * m2_q_q[QW-1:32];
      m3_hl_q  <= m2_q2_q[41:32] * m2_q_q[31:0];
      m3_hh_q  <= m2_q2_q[41:32] * m2_q_q[QW-1:32];
      m4_x_q   <= m4_sum[78:32];
      m5_ll_q  <= m4_x_q[31:0] * m4_x_q[31:0];
      m5_lh_q  <= m4_x_q[31:0] * m4_x_q[46:32];
      m5_hh_q  <= m4_x_q[46:32] * m4_x_q[46:32];
      m5_x_q   <= m4_x_q;
      m6_x2_q  <= m6_sum[93:32];
      m6_x_q   <= m5_x_q;
      m7_neg_q <= m7_neg;
      m7_t_q   <= m7_neg ? {15'b0, m6_x_q} - m6_x2_q : m6_x2_q - {15'b0, m6_x_q};
      m8_tl_q  <= m7_t_q[31:0] * eps_q;
      m8_th_q  <= m7_t_q[61:32] * eps_q;
      m8_neg_q <= m7_neg_q;
      m9_mag_q <= m9_sum[85:30];
      m9_neg_q <= m8_neg_q;
    end
  end

  // final select
  res_t  res_d;
  side_t fs;
  assign fs = m_side_q[8];

  always_comb begin
    logic [EnergyW-1:0] neg_mag;
    neg_mag      = -m9_mag_q[EnergyW-1:0];
    res_d.dx     = fs.dx;
    res_d.dy     = fs.dy;
    res_d.dz     = fs.dz;
    res_d.pdist  = m_dist_q[8];
    res_d.warn   = 1'b0;
    if (fs.zero) begin
      res_d.energy = EMax;
      res_d.sat    = 1'b1;
    end else if (fs.big) begin
      res_d.sat    = (eps_q != '0);
      res_d.energy = (eps_q != '0) ? EMax : '0;
    end else if (!m9_neg_q) begin
      res_d.sat    = (m9_mag_q > {24'b0, EMax});
      res_d.energy = res_d.sat ? EMax : m9_mag_q[EnergyW-1:0];
    end else begin
      res_d.sat    = (m9_mag_q > {24'b0, EMin});
      res_d.energy = res_d.sat ? EMin : neg_mag;
      res_d.warn   = fs.close && (m9_mag_q != '0);
    end
  end

  // output register plus skid
  logic take;
  assign take = out_vld_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (take) begin
        skid_vld_q <= 1'b0;
      end
    end else if (m_vld_q[8]) begin
      if (out_vld_q && !take) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (take) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (m_vld_q[8]) begin
      if (out_vld_q && !take) begin
        skid_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.energy, out_q.pdist, out_q.dz, out_q.dy, out_q.dx};
  assign m_axis_tuser  = {out_q.warn, out_q.sat};

endmodule
